### src/rlae_pkg.sv
package rlae_pkg;

  // Result codes
  localparam logic [1:0] KIND_EVICT  = 2'd0;
  localparam logic [1:0] KIND_GRANT  = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  // Field widths
  localparam int SIZE_W = 9;
  localparam int KIND_W = 2;
  localparam int OFF_W  = 13;
  localparam int LEN_W  = 9;
  localparam int ENT_W  = LEN_W + 1;
  localparam int CNT_W  = 6;

  // Reported evictions per request stop at this count
  localparam logic [CNT_W-1:0] EVICT_MAX = 6'd63;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOP,
    ST_FETCH,
    ST_EVAL
  } state_t;

  // Sequencer to datapath
  typedef struct packed {
    logic busy;
    logic clear;
    logic accept;
    logic reject;
    logic grant;
    logic wrap;
    logic eval;
  } ctrl_t;

  // Datapath to sequencer
  typedef struct packed {
    logic clr_done;
    logic size_ok;
    logic short_room;
    logic wrap_now;
  } stat_t;

endpackage

### src/ring_log_allocator_evict_oldest_unit.sv
// A rejected item gives its result in the cycle after start. A granted item steps
// over the oldest records in the record table, one table read per step, with an
// extra fetch step if the ring wraps, before its grant shows.
// After a grant, a new item is taken only once busy is low again, as the grant shows.
// Reset: a clearing pass writes every record-table entry, with busy high.
// Results last one cycle each; the receiver cannot stall them.
module ring_log_allocator_evict_oldest_unit
  import rlae_pkg::*;
#(
  parameter int BUF_BYTES = 4096,
  parameter int HDR_BYTES = 16,
  parameter int MAX_REQ   = 480
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [SIZE_W-1:0] in_size,
  output logic              out_valid,
  output logic [KIND_W-1:0] out_kind,
  output logic [OFF_W-1:0]  out_offset,
  output logic [LEN_W-1:0]  out_length,
  output logic              out_wrapped,
  output logic              out_last
);

  ctrl_t ctrl;
  stat_t stat;

  assign busy = ctrl.busy;

  rlae_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  rlae_dp #(
    .BUF_BYTES (BUF_BYTES),
    .HDR_BYTES (HDR_BYTES),
    .MAX_REQ   (MAX_REQ)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_size     (in_size),
    .ctrl        (ctrl),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_kind    (out_kind),
    .out_offset  (out_offset),
    .out_length  (out_length),
    .out_wrapped (out_wrapped),
    .out_last    (out_last)
  );

endmodule

### src/rlae_seq.sv
module rlae_seq
  import rlae_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  stat_t stat,
  output ctrl_t ctrl
);

  state_t state_r;
  state_t state_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (stat.clr_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (start && stat.size_ok) state_nxt = ST_LOOP;
      end
      ST_LOOP: begin
        if (!stat.short_room) state_nxt = ST_IDLE;
        else if (stat.wrap_now) state_nxt = ST_FETCH;
        else state_nxt = ST_EVAL;
      end
      ST_FETCH: state_nxt = ST_EVAL;
      ST_EVAL:  state_nxt = ST_LOOP;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_CLEAR;
    else state_r <= state_nxt;
  end

  // Decode datapath controls
  always_comb begin
    ctrl = '0;
    ctrl.busy = 1'b1;
    unique case (state_r)
      ST_CLEAR: ctrl.clear = 1'b1;
      ST_IDLE: begin
        ctrl.busy   = 1'b0;
        ctrl.accept = start && stat.size_ok;
        ctrl.reject = start && !stat.size_ok;
      end
      ST_LOOP: begin
        ctrl.grant = !stat.short_room;
        ctrl.wrap  = stat.short_room && stat.wrap_now;
      end
      ST_FETCH: ;
      ST_EVAL:  ctrl.eval = 1'b1;
      default:  ;
    endcase
  end

endmodule

### src/rlae_dp.sv
module rlae_dp
  import rlae_pkg::*;
#(
  parameter int BUF_BYTES = 4096,
  parameter int HDR_BYTES = 16,
  parameter int MAX_REQ   = 480
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [SIZE_W-1:0] in_size,
  input  ctrl_t             ctrl,
  output stat_t             stat,
  output logic              out_valid,
  output logic [KIND_W-1:0] out_kind,
  output logic [OFF_W-1:0]  out_offset,
  output logic [LEN_W-1:0]  out_length,
  output logic              out_wrapped,
  output logic              out_last
);

  localparam int PW = $clog2(BUF_BYTES + 1);
  localparam int AW = PW + 2;
  localparam int IW = $clog2(BUF_BYTES);
  localparam logic [AW-1:0] BUF_A = AW'(BUF_BYTES);
  localparam logic [AW-1:0] HDR_A = AW'(HDR_BYTES);
  localparam logic [AW-1:0] MAX_A = AW'(MAX_REQ);
  localparam logic [PW-1:0] BUF_P = PW'(BUF_BYTES);
  localparam logic [IW-1:0] LAST_IDX = IW'(BUF_BYTES - 1);

  logic [ENT_W-1:0] mem [BUF_BYTES];
  logic [ENT_W-1:0] rd_r;

  logic [PW-1:0]     wp_r, wp_nxt;
  logic [PW-1:0]     op_r, op_nxt;
  logic [AW-1:0]     avail_r, avail_nxt;
  logic [SIZE_W-1:0] req_r;
  logic              wr_r;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [IW-1:0]     clr_r;

  logic              mem_we;
  logic [IW-1:0]     mem_waddr;
  logic [ENT_W-1:0]  mem_wdata;

  logic [AW-1:0]    size_a, req_a, wp_a, op_a;
  logic [LEN_W-1:0] rd_len;
  logic             rd_hit;
  logic             wp_hdr_ok;

  assign size_a = AW'(in_size);
  assign req_a  = AW'(req_r);
  assign wp_a   = AW'(wp_r);
  assign op_a   = AW'(op_r);
  assign rd_len = rd_r[LEN_W-1:0];
  assign rd_hit = rd_r[ENT_W-1] && (rd_len != '0);
  assign wp_hdr_ok = (wp_a + HDR_A) <= BUF_A;

  // Status for the sequencer
  always_comb begin
    stat.clr_done   = (clr_r == LAST_IDX);
    stat.size_ok    = !(size_a < HDR_A || size_a > MAX_A || size_a > BUF_A);
    stat.short_room = avail_r < req_a;
    stat.wrap_now   = (op_a >= BUF_A) || ((op_a + HDR_A) > BUF_A);
  end

  // Pointer and room updates
  always_comb begin
    wp_nxt    = wp_r;
    op_nxt    = op_r;
    avail_nxt = avail_r;
    n_nxt     = n_r;
    if (ctrl.accept) begin
      avail_nxt = (op_r >= wp_r) ? AW'(op_r - wp_r) : '0;
      n_nxt     = '0;
    end else if (ctrl.grant) begin
      wp_nxt = wp_r + PW'(req_r);
    end else if (ctrl.wrap) begin
      wp_nxt    = '0;
      op_nxt    = '0;
      avail_nxt = '0;
    end else if (ctrl.eval) begin
      if (rd_hit) begin
        avail_nxt = avail_r + AW'(rd_len);
        op_nxt    = op_r + PW'(rd_len);
        if (n_r < EVICT_MAX) n_nxt = n_r + 1'b1;
      end else begin
        avail_nxt = BUF_A - wp_a;
        op_nxt    = BUF_P;
      end
    end
  end

  // Table write port
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = op_r[IW-1:0];
    mem_wdata = '0;
    if (ctrl.clear) begin
      mem_we    = 1'b1;
      mem_waddr = clr_r;
    end else if (ctrl.grant) begin
      mem_we    = wp_r < BUF_P;
      mem_waddr = wp_r[IW-1:0];
      mem_wdata = {1'b1, req_r};
    end else if (ctrl.wrap) begin
      mem_we    = wp_hdr_ok;
      mem_waddr = wp_r[IW-1:0];
    end else if (ctrl.eval) begin
      mem_we = rd_hit;
    end
  end

  // Record table: one write, one registered read at the oldest record
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_r <= mem[op_r[IW-1:0]];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      op_r    <= BUF_P;
      avail_r <= '0;
      n_r     <= '0;
      wr_r    <= 1'b0;
      clr_r   <= '0;
    end else begin
      wp_r    <= wp_nxt;
      op_r    <= op_nxt;
      avail_r <= avail_nxt;
      n_r     <= n_nxt;
      if (ctrl.accept) wr_r <= 1'b0;
      else if (ctrl.wrap) wr_r <= 1'b1;
      if (ctrl.clear && !stat.clr_done) clr_r <= clr_r + 1'b1;
    end
  end

  // Hold the request size
  always_ff @(posedge clk) begin
    if (ctrl.accept) req_r <= in_size;
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else out_valid <= ctrl.reject || ctrl.grant || (ctrl.eval && rd_hit && n_r < EVICT_MAX);
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (ctrl.reject) begin
      out_kind    <= KIND_REJECT;
      out_offset  <= '0;
      out_length  <= '0;
      out_wrapped <= 1'b0;
      out_last    <= 1'b1;
    end else if (ctrl.grant) begin
      out_kind    <= KIND_GRANT;
      out_offset  <= OFF_W'(wp_r);
      out_length  <= req_r;
      out_wrapped <= wr_r;
      out_last    <= 1'b1;
    end else if (ctrl.eval) begin
      out_kind    <= KIND_EVICT;
      out_offset  <= OFF_W'(op_r);
      out_length  <= rd_len;
      out_wrapped <= wr_r;
      out_last    <= 1'b0;
    end
  end

endmodule
